/* hdl/aes_rt_pkg.sv */
package aes_rt_pkg;

	typedef logic [15:0][7:0] state_t;

	typedef enum logic [2:0] {
		KIND_SUB   = 3'd0,
		KIND_SHIFT = 3'd1,
		KIND_MIX   = 3'd2,
		KIND_KEY   = 3'd3,
		KIND_FULL  = 3'd4,
		KIND_FINAL = 3'd5
	} kind_t;

	localparam logic [7:0] GF_POLY = 8'h1B;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic state_t byte_subst(input state_t s);
		state_t t;
		for (int k = 0; k < 16; k++) begin
			t[k] = SBOX[s[k]];
		end
		return t;
	endfunction

	function automatic state_t row_rotate(input state_t s);
		state_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[r*4 + c] = s[r*4 + ((c + r) % 4)];
			end
		end
		return t;
	endfunction

	function automatic state_t column_mix(input state_t s);
		state_t t;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[c];
			a1 = s[c + 4];
			a2 = s[c + 8];
			a3 = s[c + 12];
			d0 = xtime(a0);
			d1 = xtime(a1);
			d2 = xtime(a2);
			d3 = xtime(a3);
			t[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			t[c + 4]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			t[c + 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			t[c + 12] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
		return t;
	endfunction

endpackage

/* hdl/aes_encrypt_round_transform.sv */
// AES encryption round transform.
// Input channel (in_valid/in_ready) carries kind, a 128-bit state and a
// 128-bit round key; output channel (out_valid/out_ready) returns the
// transformed state. Bytes are row-major, byte k at bits 8k+7:8k of the
// lo/hi halves. Kind selects SubBytes, ShiftRows, MixColumns,
// AddRoundKey, a full round or a final round; other codes pass through.
// Path: an accepted transaction goes into the input register, then through
// S-box/ShiftRows/MixColumns/key logic into the result register, which
// drives out_valid and the output state.
// Throughput: one transaction per cycle; both stages advance together
// whenever the result register is empty or being taken.
// Reset clears both stage valid flags; no transaction is pending after it.
// When the receiver stalls, the result register holds and the input
// register keeps one more transaction, then in_ready drops until
// out_ready returns.
module aes_encrypt_round_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [63:0] state_in_lo,
	input  logic [63:0] state_in_hi,
	input  logic [63:0] key_lo,
	input  logic [63:0] key_hi,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] state_out_lo,
	output logic [63:0] state_out_hi
);
	import aes_rt_pkg::*;

	logic       vld_s1;
	logic [2:0] kind_s1;
	state_t     state_s1;
	state_t     key_s1;
	logic       vld_s2;
	state_t     state_s2;
	state_t     result;
	logic       adv_s2;
	logic       adv_s1;

	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			kind_s1  <= kind;
			state_s1 <= {state_in_hi, state_in_lo};
			key_s1   <= {key_hi, key_lo};
		end
		if (adv_s2 && vld_s1) begin
			state_s2 <= result;
		end
	end

	aes_rt_datapath u_datapath (
		.kind      (kind_s1),
		.state_in  (state_s1),
		.key       (key_s1),
		.state_out (result)
	);

	assign out_valid    = vld_s2;
	assign state_out_lo = state_s2[7:0];
	assign state_out_hi = state_s2[15:8];

endmodule

/* hdl/aes_rt_datapath.sv */
module aes_rt_datapath (
	input  logic [2:0]      kind,
	input  aes_rt_pkg::state_t state_in,
	input  aes_rt_pkg::state_t key,
	output aes_rt_pkg::state_t state_out
);
	import aes_rt_pkg::*;

	state_t sub_st;
	state_t shift_in;
	state_t shift_st;
	state_t mix_in;
	state_t mix_st;
	logic   composed;

	assign composed = (kind == KIND_FULL) || (kind == KIND_FINAL);
	assign sub_st   = byte_subst(state_in);
	assign shift_in = composed ? sub_st : state_in;
	assign shift_st = row_rotate(shift_in);
	assign mix_in   = composed ? shift_st : state_in;
	assign mix_st   = column_mix(mix_in);

	always_comb begin
		unique case (kind)
			KIND_SUB:   state_out = sub_st;
			KIND_SHIFT: state_out = shift_st;
			KIND_MIX:   state_out = mix_st;
			KIND_KEY:   state_out = state_in ^ key;
			KIND_FULL:  state_out = mix_st ^ key;
			KIND_FINAL: state_out = shift_st ^ key;
			default:    state_out = state_in;
		endcase
	end

endmodule

/* sim/aes_encrypt_round_transform_tb.sv */
`timescale 1ns / 1ps

module aes_encrypt_round_transform_tb;
	import aes_rt_pkg::*;

	localparam logic [2:0] KIND_RSVD_6 = 3'd6;
	localparam logic [2:0] KIND_RSVD_7 = 3'd7;
	localparam logic [7:0] AES_POLY    = 8'h1B;
	localparam logic [7:0] SBOX_AFFINE = 8'h63;
	localparam int         NUM_PHASES  = 5;
	localparam int         LONG_HOLD   = 300;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] s_lo;
		logic [63:0] s_hi;
		logic [63:0] k_lo;
		logic [63:0] k_hi;
	} block_req_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [2:0]  kind         = '0;
	logic [63:0] state_in_lo  = '0;
	logic [63:0] state_in_hi  = '0;
	logic [63:0] key_lo       = '0;
	logic [63:0] key_hi       = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [63:0] state_out_lo;
	logic [63:0] state_out_hi;

	block_req_t  pending_blocks [$];
	state_t      expected_states [$];
	logic [7:0]  sbox_tbl [256];
	bit          in_taken   = 1'b0;
	int          send_idle  = 0;
	int          recv_stall = 0;
	int          hold_left  = 0;
	int          err_count  = 0;
	int          phase_send [NUM_PHASES] = '{0, 51, 0, 22, 0};
	int          phase_recv [NUM_PHASES] = '{0, 0, 51, 22, 0};
	int          phase_len  [NUM_PHASES] = '{300, 300, 300, 300, 250};

	aes_encrypt_round_transform u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.state_in_lo  (state_in_lo),
		.state_in_hi  (state_in_hi),
		.key_lo       (key_lo),
		.key_hi       (key_hi),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.state_out_lo (state_out_lo),
		.state_out_hi (state_out_hi)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? AES_POLY : 8'h00);
		end
		return p;
	endfunction

	// S-box from the multiplicative inverse and the affine map
	initial begin : build_sbox
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			end
			sbox_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
				{inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ SBOX_AFFINE;
		end
	end

	function automatic state_t round_result(logic [2:0] op, state_t s, state_t k);
		state_t t;
		state_t u;
		bit     use_sub;
		bit     use_shift;
		bit     use_mix;
		bit     use_key;
		logic [7:0] a [4];
		use_sub   = op inside {KIND_SUB, KIND_FULL, KIND_FINAL};
		use_shift = op inside {KIND_SHIFT, KIND_FULL, KIND_FINAL};
		use_mix   = op inside {KIND_MIX, KIND_FULL};
		use_key   = op inside {KIND_KEY, KIND_FULL, KIND_FINAL};
		t = s;
		if (use_sub) begin
			for (int i = 0; i < 16; i++)
				t[i] = sbox_tbl[t[i]];
		end
		if (use_shift) begin
			u = t;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					t[r*4 + c] = u[r*4 + ((c + r) % 4)];
		end
		if (use_mix) begin
			for (int c = 0; c < 4; c++) begin
				for (int i = 0; i < 4; i++)
					a[i] = t[c + 4*i];
				for (int i = 0; i < 4; i++)
					t[c + 4*i] = gf_mul(a[i], 8'h02) ^ gf_mul(a[(i+1)%4], 8'h03) ^
						a[(i+2)%4] ^ a[(i+3)%4];
			end
		end
		if (use_key)
			t ^= k;
		return t;
	endfunction

	task automatic add_block(logic [2:0] op, logic [63:0] slo, logic [63:0] shi,
			logic [63:0] klo, logic [63:0] khi);
		block_req_t b;
		b.kind = op;
		b.s_lo = slo;
		b.s_hi = shi;
		b.k_lo = klo;
		b.k_hi = khi;
		pending_blocks.push_back(b);
	endtask

	function automatic logic [63:0] pick_word();
		logic [63:0] w;
		logic [7:0]  specials [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		case ($urandom_range(9))
		0: w = '0;
		1: w = '1;
		2: begin
			for (int i = 0; i < 8; i++)
				w[8*i +: 8] = specials[$urandom_range(4)];
		end
		default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] pick_kind();
		if ($urandom_range(15) < 14)
			return 3'($urandom_range(KIND_FINAL));
		return 3'($urandom_range(KIND_RSVD_7, KIND_RSVD_6));
	endfunction

	task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch %s: expected %h got %h", field, want, got);
	endtask

	task automatic wait_drained();
		while (!(pending_blocks.size() == 0 && !in_valid && expected_states.size() == 0))
			@(posedge clk);
	endtask

	always @(negedge clk) begin : driver
		block_req_t cur;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle) begin
				cur = pending_blocks.pop_front();
				in_valid    <= 1'b1;
				kind        <= cur.kind;
				state_in_lo <= cur.s_lo;
				state_in_hi <= cur.s_hi;
				key_lo      <= cur.k_lo;
				key_hi      <= cur.k_hi;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin : monitor
		state_t want;
		if (in_valid && in_ready) begin
			expected_states.push_back(round_result(kind, {state_in_hi, state_in_lo},
				{key_hi, key_lo}));
			in_taken = 1'b1;
		end
		if (out_valid && out_ready) begin
			if (expected_states.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected transaction: %h %h", state_out_hi, state_out_lo);
			end else begin
				want = expected_states.pop_front();
				if (state_out_lo !== want[7:0])
					note_mismatch("state_out_lo", want[7:0], state_out_lo);
				if (state_out_hi !== want[15:8])
					note_mismatch("state_out_hi", want[15:8], state_out_hi);
			end
		end
	end

	initial begin
		#200000;
		$display("** aes_encrypt_round_transform: FAILED **");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int kd = KIND_SUB; kd <= KIND_RSVD_7; kd++) begin
			add_block(3'(kd), '0, '0, '1, '1);
			add_block(3'(kd), '1, '1, '0, '0);
			add_block(3'(kd), {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
		end
		add_block(KIND_MIX, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, '0, '0);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle  = phase_send[p];
			recv_stall = phase_recv[p];
			for (int n = 0; n < phase_len[p]; n++)
				add_block(pick_kind(), pick_word(), pick_word(), pick_word(), pick_word());
			if (p == NUM_PHASES - 1) begin
				repeat (20) @(posedge clk);
				hold_left = LONG_HOLD;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (expected_states.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("** aes_encrypt_round_transform: PASSED **");
		else
			$display("** aes_encrypt_round_transform: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
hdl/aes_rt_pkg.sv
hdl/aes_rt_datapath.sv
hdl/aes_encrypt_round_transform.sv
sim/aes_encrypt_round_transform_tb.sv
